// ===== rtl/core/sos_pkg.sv =====
package sos_pkg;

   localparam int MAX_DEPTH      = 1024;
   localparam int WORD_BITS      = 64;
   localparam int ADDR_BITS      = $clog2(MAX_DEPTH);
   localparam int DEPTH_BITS     = ADDR_BITS + 1;
   localparam int POS_LIMIT      = 16;

   localparam int OP_BITS        = 3;
   localparam int PORT_WORD_BITS = 64;
   localparam int POS_BITS       = 5;
   localparam int COUNT_BITS     = 3;
   localparam int STATUS_BITS    = 2;

   localparam logic [OP_BITS-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_BITS-1:0] OP_DUP  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_SWAP = 3'd2;
   localparam logic [OP_BITS-1:0] OP_POP  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_AND  = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic                 known;
      logic [WORD_BITS-1:0] value;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{known: 1'b0, value: '0};

   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      entry_type            wr_entry;
   } mem_req_type;

endpackage

// ===== rtl/core/sos_stack_ram.sv =====
module sos_stack_ram (
   input  logic                clock,
   input  sos_pkg::mem_req_type mem_req,
   output sos_pkg::entry_type  rd_entry
);
   import sos_pkg::*;

   entry_type mem_ff [MAX_DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_entry;
      end
      if (mem_req.rd_en) begin
         rd_entry_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== rtl/core/sos_ctrl.sv =====
module sos_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [sos_pkg::OP_BITS-1:0]          req_op,
   input  logic [sos_pkg::PORT_WORD_BITS-1:0]   req_push_value,
   input  logic [sos_pkg::POS_BITS-1:0]         req_position,
   input  logic [sos_pkg::COUNT_BITS-1:0]       req_pop_count,
   input  logic [sos_pkg::COUNT_BITS-1:0]       req_push_count,
   input  sos_pkg::entry_type                   rd_entry,
   output sos_pkg::mem_req_type                 mem_req,
   output logic                                 rsp_valid,
   output logic [sos_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [sos_pkg::DEPTH_BITS-1:0]       rsp_depth,
   output logic                                 rsp_top_known,
   output logic [sos_pkg::PORT_WORD_BITS-1:0]   rsp_top_value
);
   import sos_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_FILL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [OP_BITS-1:0]     op_ff, op_in;
   logic [WORD_BITS-1:0]   pval_ff, pval_in;
   logic [COUNT_BITS-1:0]  npop_ff, npop_in, npush_ff, npush_in, cnt_ff, cnt_in;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [ADDR_BITS-1:0]   raddr_ff, raddr_in, waddr_ff, waddr_in;
   entry_type              top_ff, top_in, wentry_ff, wentry_in;
   logic [STATUS_BITS-1:0] status_ff, status_in, status_chk;

   logic                   accept;
   logic                   pos_bad;
   logic                   both_known;
   logic [DEPTH_BITS-1:0]  pos_ext, npop_ext, npush_ext, nd_acc, nd_exec, rd_full;
   entry_type              and_entry, push_entry;

   assign busy   = (state_ff == S_EXEC) || (state_ff == S_FILL);
   assign accept = start && !busy;

   always_comb begin
      pos_ext   = DEPTH_BITS'(req_position);
      npop_ext  = DEPTH_BITS'(req_pop_count);
      npush_ext = DEPTH_BITS'(req_push_count);
      nd_acc    = depth_ff - npop_ext;
      pos_bad   = (req_position == '0) || (req_position > POS_BITS'(POS_LIMIT));
      status_chk = ST_OK;
      rd_full    = depth_ff;
      unique case (req_op)
         OP_PUSH: begin
            if (depth_ff >= DEPTH_BITS'(MAX_DEPTH)) begin
               status_chk = ST_OVERFLOW;
            end
         end
         OP_DUP: begin
            rd_full = depth_ff - pos_ext;
            priority if (pos_bad || pos_ext > depth_ff) begin
               status_chk = ST_UNDERFLOW;
            end else if (depth_ff >= DEPTH_BITS'(MAX_DEPTH)) begin
               status_chk = ST_OVERFLOW;
            end
         end
         OP_SWAP: begin
            rd_full = depth_ff - pos_ext - DEPTH_BITS'(1);
            if (pos_bad || (pos_ext + DEPTH_BITS'(1)) > depth_ff) begin
               status_chk = ST_UNDERFLOW;
            end
         end
         OP_POP: begin
            rd_full = depth_ff - DEPTH_BITS'(2);
            if (depth_ff == '0) begin
               status_chk = ST_UNDERFLOW;
            end
         end
         OP_AND: begin
            rd_full = depth_ff - DEPTH_BITS'(2);
            if (depth_ff < DEPTH_BITS'(2)) begin
               status_chk = ST_UNDERFLOW;
            end
         end
         default: begin
            rd_full = nd_acc - DEPTH_BITS'(1);
            priority if (npop_ext > depth_ff) begin
               status_chk = ST_UNDERFLOW;
            end else if ((nd_acc + npush_ext) > DEPTH_BITS'(MAX_DEPTH)) begin
               status_chk = ST_OVERFLOW;
            end
         end
      endcase
   end

   always_comb begin
      both_known       = top_ff.known && rd_entry.known;
      and_entry.known  = both_known;
      and_entry.value  = both_known ? (top_ff.value & rd_entry.value) : '0;
      push_entry.known = 1'b1;
      push_entry.value = pval_ff;
      nd_exec          = depth_ff - DEPTH_BITS'(npop_ff);

      state_in  = state_ff;
      op_in     = op_ff;
      pval_in   = pval_ff;
      npop_in   = npop_ff;
      npush_in  = npush_ff;
      cnt_in    = cnt_ff;
      depth_in  = depth_ff;
      raddr_in  = raddr_ff;
      waddr_in  = waddr_ff;
      top_in    = top_ff;
      wentry_in = wentry_ff;
      status_in = status_ff;

      mem_req.rd_en    = accept;
      mem_req.rd_addr  = rd_full[ADDR_BITS-1:0];
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = waddr_ff;
      mem_req.wr_entry = wentry_ff;

      unique case (state_ff)
         S_IDLE, S_DONE: begin
            if (accept) begin
               op_in     = req_op;
               pval_in   = WORD_BITS'(req_push_value);
               npop_in   = req_pop_count;
               npush_in  = req_push_count;
               raddr_in  = rd_full[ADDR_BITS-1:0];
               status_in = status_chk;
               state_in  = (status_chk == ST_OK) ? S_EXEC : S_DONE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            unique case (op_ff)
               OP_PUSH: begin
                  mem_req.wr_en    = 1'b1;
                  mem_req.wr_addr  = depth_ff[ADDR_BITS-1:0];
                  mem_req.wr_entry = push_entry;
                  top_in           = push_entry;
                  depth_in         = depth_ff + DEPTH_BITS'(1);
               end
               OP_DUP: begin
                  mem_req.wr_en    = 1'b1;
                  mem_req.wr_addr  = depth_ff[ADDR_BITS-1:0];
                  mem_req.wr_entry = rd_entry;
                  top_in           = rd_entry;
                  depth_in         = depth_ff + DEPTH_BITS'(1);
               end
               OP_SWAP: begin
                  mem_req.wr_en    = 1'b1;
                  mem_req.wr_addr  = raddr_ff;
                  mem_req.wr_entry = top_ff;
                  top_in           = rd_entry;
                  waddr_in         = depth_ff[ADDR_BITS-1:0] - ADDR_BITS'(1);
                  wentry_in        = rd_entry;
                  cnt_in           = COUNT_BITS'(1);
                  state_in         = S_FILL;
               end
               OP_POP: begin
                  top_in   = (depth_ff >= DEPTH_BITS'(2)) ? rd_entry : EMPTY_ENTRY;
                  depth_in = depth_ff - DEPTH_BITS'(1);
               end
               OP_AND: begin
                  mem_req.wr_en    = 1'b1;
                  mem_req.wr_addr  = raddr_ff;
                  mem_req.wr_entry = and_entry;
                  top_in           = and_entry;
                  depth_in         = depth_ff - DEPTH_BITS'(1);
               end
               default: begin
                  depth_in = nd_exec + DEPTH_BITS'(npush_ff);
                  if (npush_ff != '0) begin
                     top_in    = EMPTY_ENTRY;
                     waddr_in  = nd_exec[ADDR_BITS-1:0];
                     wentry_in = EMPTY_ENTRY;
                     cnt_in    = npush_ff;
                     state_in  = S_FILL;
                  end else begin
                     top_in = (nd_exec != '0) ? rd_entry : EMPTY_ENTRY;
                  end
               end
            endcase
         end
         S_FILL: begin
            mem_req.wr_en = 1'b1;
            waddr_in      = waddr_ff + ADDR_BITS'(1);
            cnt_in        = cnt_ff - COUNT_BITS'(1);
            if (cnt_ff == COUNT_BITS'(1)) begin
               state_in = S_DONE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         depth_ff  <= '0;
         top_ff    <= EMPTY_ENTRY;
         cnt_ff    <= '0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         depth_ff  <= depth_in;
         top_ff    <= top_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
      op_ff     <= op_in;
      pval_ff   <= pval_in;
      npop_ff   <= npop_in;
      npush_ff  <= npush_in;
      raddr_ff  <= raddr_in;
      waddr_ff  <= waddr_in;
      wentry_ff <= wentry_in;
   end

   assign rsp_valid     = (state_ff == S_DONE);
   assign rsp_status    = status_ff;
   assign rsp_depth     = depth_ff;
   assign rsp_top_known = top_ff.known;
   assign rsp_top_value = top_ff.known ? PORT_WORD_BITS'(top_ff.value) : '0;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_BITS'(MAX_DEPTH))
      else $error("stack depth above capacity");

   a_flagged_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff != ST_OK) |-> depth_ff == $past(depth_ff))
      else $error("flagged item changed the depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item was dropped");

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (cnt_ff != '0))
      else $error("fill pass with no entries left");

endmodule

// ===== rtl/core/symbolic_operand_stack.sv =====
// Operand stack with a known/unknown tag on every entry, kept in a single-port-read,
// single-port-write memory with a registered read. An item is accepted when start
// is high and busy is low; its result appears on the rsp_ ports for exactly one cycle with
// rsp_valid high, and the receiver cannot hold it off, so it must take the result in that
// cycle. Busy is low during that result cycle, so the next item may be started then.
// A flagged item (overflow, underflow or bad position) goes straight to its result and
// leaves the stack alone; push, dup, pop, and, and an other instruction that pushes nothing
// take a memory read, then an update; swap needs a further write state, since both entries
// are written back through the one write port; an other instruction pushing n unknown
// entries writes them in a fill state, one write per cycle. The memory needs no clearing
// after reset: only entries that were pushed are ever used.
module symbolic_operand_stack (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [sos_pkg::OP_BITS-1:0]          req_op,
   input  logic [sos_pkg::PORT_WORD_BITS-1:0]   req_push_value,
   input  logic [sos_pkg::POS_BITS-1:0]         req_position,
   input  logic [sos_pkg::COUNT_BITS-1:0]       req_pop_count,
   input  logic [sos_pkg::COUNT_BITS-1:0]       req_push_count,
   output logic                                 rsp_valid,
   output logic [sos_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [sos_pkg::DEPTH_BITS-1:0]       rsp_depth,
   output logic                                 rsp_top_known,
   output logic [sos_pkg::PORT_WORD_BITS-1:0]   rsp_top_value
);
   import sos_pkg::*;

   mem_req_type mem_req;
   entry_type   rd_entry;

   sos_stack_ram u_ram (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_entry (rd_entry)
   );

   sos_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .req_position   (req_position),
      .req_pop_count  (req_pop_count),
      .req_push_count (req_push_count),
      .rd_entry       (rd_entry),
      .mem_req        (mem_req),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_depth      (rsp_depth),
      .rsp_top_known  (rsp_top_known),
      .rsp_top_value  (rsp_top_value)
   );

endmodule
